### design/pds_pkg.sv
// Shared constants, item and stage types, and saturation helpers for the PCM-to-DSD modulator.
package pds_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CHAN_W    = 6;
    localparam int PCM_W     = 32;
    localparam int SMP_W     = 25;
    localparam int DIFF_W    = 26;
    localparam int X_W       = 30;
    localparam int INT_W     = 36;
    localparam int SUM_W     = 38;
    localparam int DSD_W     = 16;
    localparam int SUB_STEPS = 16;

    // issue stage, prep stage, then two stages per sub-step
    localparam int NSTG      = 2 + 2 * SUB_STEPS;

    localparam int FQ_DEPTH  = 4;
    localparam int FQ_AW     = $clog2(FQ_DEPTH);

    localparam logic [DSD_W-1:0]        BAD_WORD = 16'h6969;
    localparam logic signed [PCM_W-1:0] HALF_PCM = 32'sd8388608;
    localparam logic signed [X_W-1:0]   ONE_FIX  = 30'sd268435456;

    typedef struct packed {
        logic                     bad;
        logic [CH_W-1:0]          ch;
        logic signed [SMP_W-1:0]  cur;
    } t_item;

    typedef struct packed {
        logic signed [SMP_W-1:0]  last;
        logic signed [INT_W-1:0]  i1;
        logic signed [INT_W-1:0]  i2;
        logic                     fb;
    } t_chstate;

    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic [CH_W-1:0]          ch;
        logic signed [SMP_W-1:0]  cur;
        logic signed [SMP_W-1:0]  prev;
        logic signed [DIFF_W-1:0] diff;
        logic signed [X_W-1:0]    x;
        logic signed [INT_W-1:0]  i1;
        logic signed [INT_W-1:0]  i2;
        logic                     fb;
        logic [DSD_W-1:0]         bits;
    } t_stage;

    // clip a 38-bit sum to the 36-bit integrator range
    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] v);
        logic signed [INT_W-1:0] res;
        if ((v[SUM_W-1:INT_W-1] == '0) || (v[SUM_W-1:INT_W-1] == '1)) begin
            res = v[INT_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(INT_W-1){1'b1}}};
        end
        return res;
    endfunction

    // fed-back decision as +/-1.0 with 28 fraction bits
    function automatic logic signed [X_W-1:0] fb_val(input logic fb);
        return fb ? ONE_FIX : -ONE_FIX;
    endfunction

endpackage

### design/pds_front.sv
// Input stage: takes items, flags bad channels, clamps the halved sample.
module pds_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pds_pkg::CHAN_W-1:0]        i_chan,
    input  logic signed [pds_pkg::PCM_W-1:0]  i_pcm_sample,
    output logic                              o_push,
    output pds_pkg::t_item                    o_item,
    input  logic                              i_full
);
    import pds_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   take;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign take    = i_valid && !o_stall;
    assign o_item  = r_item;

    always_comb begin
        n_item.bad = !({1'b0, i_chan} < (CHAN_W + 1)'(CHANNELS));
        n_item.ch  = n_item.bad ? '0 : i_chan[CH_W-1:0];
        // Q8.23 read as Q.24 is already the halved value
        if (i_pcm_sample > HALF_PCM) begin
            n_item.cur = HALF_PCM[SMP_W-1:0];
        end else if (i_pcm_sample < -HALF_PCM) begin
            n_item.cur = -HALF_PCM[SMP_W-1:0];
        end else begin
            n_item.cur = i_pcm_sample[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

### design/pds_fifo.sv
// Short item queue between the front stage and the modulator pipeline.
module pds_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pds_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output pds_pkg::t_item  o_head
);
    import pds_pkg::*;

    t_item             r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]  r_wp;
    logic [FQ_AW-1:0]  r_rp;
    logic [FQ_AW:0]    r_cnt;
    logic              do_pop;

    assign o_full       = (r_cnt == (FQ_AW + 1)'(FQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### design/pds_back.sv
// Modulator pipeline: per-channel state, sixteen two-stage sub-steps, output register.
module pds_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  pds_pkg::t_item               i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pds_pkg::DSD_W-1:0]    o_dsd_bits,
    output logic                         o_bad_channel
);
    import pds_pkg::*;

    t_chstate          r_state [CHANNELS];
    t_stage            r_stg   [NSTG];
    t_stage            n_stg   [NSTG];
    logic              r_out_valid;
    logic [DSD_W-1:0]  r_out_bits;
    logic              r_out_bad;
    logic              en;
    logic              hazard;
    t_chstate          rd;
    t_stage            last;

    assign en     = !r_out_valid || !i_stall;
    assign rd     = r_state[i_head.ch];
    assign last   = r_stg[NSTG-1];
    assign o_pop  = i_head_valid && en && !hazard;

    assign o_valid       = r_out_valid;
    assign o_dsd_bits    = r_out_bits;
    assign o_bad_channel = r_out_bad;

    // hold an item back while its channel is still in flight
    always_comb begin
        hazard = 1'b0;
        for (int j = 0; j < NSTG; j++) begin
            if (r_stg[j].valid && !r_stg[j].bad && (r_stg[j].ch == i_head.ch)) begin
                hazard = 1'b1;
            end
        end
        if (i_head.bad) begin
            hazard = 1'b0;
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [INT_W-1:0] i2n;

        sum            = '0;
        i2n            = '0;
        n_stg[0]       = '0;
        n_stg[0].valid = o_pop;
        n_stg[0].bad   = i_head.bad;
        n_stg[0].ch    = i_head.ch;
        n_stg[0].cur   = i_head.cur;
        n_stg[0].prev  = rd.last;
        n_stg[0].i1    = rd.i1;
        n_stg[0].i2    = rd.i2;
        n_stg[0].fb    = rd.fb;

        for (int j = 1; j < NSTG; j++) begin
            n_stg[j] = r_stg[j-1];
            if (j == 1) begin
                // first sub-step input: 16*prev + (cur - prev)
                n_stg[j].diff = DIFF_W'(r_stg[j-1].cur) - DIFF_W'(r_stg[j-1].prev);
                n_stg[j].x    = (X_W'(r_stg[j-1].prev) <<< 4) + X_W'(r_stg[j-1].cur)
                              - X_W'(r_stg[j-1].prev);
            end else if (j[0] == 1'b0) begin
                // first integrator
                sum = SUM_W'(r_stg[j-1].i1) + SUM_W'(r_stg[j-1].x)
                    - SUM_W'(fb_val(r_stg[j-1].fb));
                n_stg[j].i1 = sat_int(sum);
            end else begin
                // second integrator, decision, next interpolation point
                sum = SUM_W'(r_stg[j-1].i2) + SUM_W'(r_stg[j-1].i1)
                    - SUM_W'(fb_val(r_stg[j-1].fb));
                i2n           = sat_int(sum);
                n_stg[j].i2   = i2n;
                n_stg[j].fb   = !i2n[INT_W-1];
                n_stg[j].bits = {r_stg[j-1].bits[DSD_W-2:0], !i2n[INT_W-1]};
                n_stg[j].x    = r_stg[j-1].x + X_W'(r_stg[j-1].diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int j = 0; j < NSTG; j++) begin
                r_stg[j] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= '0;
            end
        end else if (en) begin
            r_out_valid <= last.valid;
            for (int j = 0; j < NSTG; j++) begin
                r_stg[j] <= n_stg[j];
            end
            if (last.valid && !last.bad) begin
                r_state[last.ch] <= '{last: last.cur, i1: last.i1, i2: last.i2, fb: last.fb};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bits <= last.bad ? BAD_WORD : last.bits;
            r_out_bad  <= last.bad;
        end
    end

endmodule

### design/pcm_to_dsd_sigma_delta.sv
// Top level of the PCM-to-DSD second-order delta-sigma modulator.
//
// Input channel (i_valid / o_stall): one item per accepted cycle, carrying a
// channel number and a signed Q8.23 PCM sample. Output channel (o_valid /
// i_stall): one item per input item, in input order: sixteen DSD bits, first
// bit in the MSB, plus a bad-channel flag (bits read 0x6969 then, state kept).
// Path from input accept to output valid: the front register loads at the
// accept edge, then queue, issue and prep stages, 32 integrator stages,
// output register.
// Throughput: one item per cycle while the output is not stalled and no item
// names a good channel still in the 34-stage pipeline; such an item waits at
// the queue head until that earlier item writes its state back, so a stream
// on a single channel issues each item only after the one before it is done.
// Reset: synchronous, active low; clears all per-channel state (samples and
// integrators to zero, last decision to -1) and empties the pipeline.
// Stall: a stalled output item holds; the pipeline freezes behind it while
// the front register and the four-entry queue keep taking items until full.
module pcm_to_dsd_sigma_delta (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pds_pkg::CHAN_W-1:0]        i_chan,
    input  logic signed [pds_pkg::PCM_W-1:0]  i_pcm_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pds_pkg::DSD_W-1:0]         o_dsd_bits,
    output logic                              o_bad_channel
);
    import pds_pkg::*;

    logic   push;
    t_item  front_item;
    logic   fq_full;
    logic   pop;
    logic   head_valid;
    t_item  head;

    // classify and clamp
    pds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chan       (i_chan),
        .i_pcm_sample (i_pcm_sample),
        .o_push       (push),
        .o_item       (front_item),
        .i_full       (fq_full)
    );

    // decouples the front from pipeline stalls and channel hazards
    pds_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (front_item),
        .o_full       (fq_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // per-channel modulator pipeline
    pds_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dsd_bits    (o_dsd_bits),
        .o_bad_channel (o_bad_channel)
    );

endmodule

### verif/tb_pcm_to_dsd_sigma_delta.sv
// Self-checking testbench for the PCM-to-DSD delta-sigma modulator: directed table, then random.
module tb_pcm_to_dsd_sigma_delta;

    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::CHANNELS;
    import pds_pkg::CH_W;
    import pds_pkg::CHAN_W;
    import pds_pkg::PCM_W;
    import pds_pkg::DSD_W;

    // Word returned for a channel number at or above the channel count.
    localparam logic [DSD_W-1:0] BAD_CHAN_WORD = 16'h6969;

    // Fixed-point constants of the modulator: 28 fraction bits inside,
    // samples held as halved Q.24, integrators 36 bits wide.
    localparam longint ONE_Q28  = 64'sd1 <<< 28;
    localparam longint HALF_Q24 = 64'sd1 <<< 23;
    localparam longint INT36_HI = (64'sd1 <<< 35) - 1;
    localparam longint INT36_LO = -(64'sd1 <<< 35);

    localparam int SUB_STEPS    = 16;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int PHASE_ITEMS  = 345;

    // One result item: the sixteen decisions and the bad-channel flag.
    typedef struct packed {
        logic [DSD_W-1:0] bits;
        logic             bad;
    } t_dsd_word;

    // A directed row; typed rows carry their expected result, the others
    // are checked against the predictor.
    typedef struct packed {
        logic [CHAN_W-1:0]       chan;
        logic signed [PCM_W-1:0] pcm;
        bit                      typed;
        t_dsd_word               word;
    } t_stim_row;

    localparam int N_ROWS = 24;

    // --------------------------------------------------------------------
    // Directed stimulus table
    // --------------------------------------------------------------------
    // First row hits a freshly reset channel: zero input with the decision
    // at -1 settles into the 0011 idle-tone pattern after a 1101 start-up.
    t_stim_row directed_rows [N_ROWS] = '{
        '{6'd0,  32'sh0000_0000, 1'b1, '{16'hD333, 1'b0}},
        // bad channels: lowest, highest, single high bits, mixed
        '{6'd8,  32'sh0000_0000, 1'b1, '{BAD_CHAN_WORD, 1'b1}},
        '{6'd63, 32'sh7FFF_FFFF, 1'b1, '{BAD_CHAN_WORD, 1'b1}},
        '{6'd32, 32'sh8000_0000, 1'b1, '{BAD_CHAN_WORD, 1'b1}},
        '{6'd56, 32'shFFFF_FFFF, 1'b1, '{BAD_CHAN_WORD, 1'b1}},
        // full-scale samples clamp to +/-0.5; full swing on one channel
        '{6'd1,  32'sh7FFF_FFFF, 1'b0, '0},
        '{6'd1,  32'sh8000_0000, 1'b0, '0},
        // exactly at the clamp points, one LSB beyond, and one LSB inside
        '{6'd2,  32'sh0080_0000, 1'b0, '0},
        '{6'd2,  32'shFF80_0000, 1'b0, '0},
        '{6'd3,  32'sh0080_0001, 1'b0, '0},
        '{6'd3,  32'shFF7F_FFFF, 1'b0, '0},
        '{6'd5,  32'sh007F_FFFF, 1'b0, '0},
        '{6'd5,  32'shFF80_0001, 1'b0, '0},
        // smallest nonzero magnitudes
        '{6'd4,  32'sh0000_0001, 1'b0, '0},
        '{6'd4,  32'shFFFF_FFFF, 1'b0, '0},
        // alternating bit patterns, both far out of range
        '{6'd6,  32'sh5555_5555, 1'b0, '0},
        '{6'd6,  32'shAAAA_AAAA, 1'b0, '0},
        // pinned at the rails to push the integrators hard
        '{6'd7,  32'sh7FFF_FFFF, 1'b0, '0},
        '{6'd7,  32'sh7FFF_FFFF, 1'b0, '0},
        '{6'd7,  32'sh8000_0000, 1'b0, '0},
        '{6'd7,  32'sh8000_0000, 1'b0, '0},
        // bad channel between good ones must leave channel 7 untouched
        '{6'd15, 32'sh1234_5678, 1'b1, '{BAD_CHAN_WORD, 1'b1}},
        '{6'd7,  32'sh0000_0000, 1'b0, '0},
        '{6'd0,  32'sh0040_0000, 1'b0, '0}
    };

    // --------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // --------------------------------------------------------------------
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [CHAN_W-1:0]        i_chan       = '0;
    logic signed [PCM_W-1:0]  i_pcm_sample = '0;
    logic                     i_stall      = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [DSD_W-1:0]         o_dsd_bits;
    logic                     o_bad_channel;

    pcm_to_dsd_sigma_delta uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_chan        (i_chan),
        .i_pcm_sample  (i_pcm_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dsd_bits    (o_dsd_bits),
        .o_bad_channel (o_bad_channel)
    );

    always #10 i_clk = ~i_clk;

    // --------------------------------------------------------------------
    // Predictor state, one modulator per channel
    // --------------------------------------------------------------------
    logic signed [24:0] chan_last [CHANNELS];   // halved, clamped sample
    logic signed [35:0] chan_int1 [CHANNELS];
    logic signed [35:0] chan_int2 [CHANNELS];
    bit                 chan_dec  [CHANNELS];   // 0 = -1, 1 = +1

    t_dsd_word pending_dsd [$];                 // results still to come

    int  send_idle_pct = 19;
    int  recv_idle_pct = 71;
    bit  hold_off      = 1'b0;
    int  mismatch_count  = 0;
    int  items_sent      = 0;
    int  bad_items       = 0;
    int  results_checked = 0;
    logic [CHAN_W-1:0] prev_chan = '0;

    function automatic longint clip36(input longint v);
        if (v > INT36_HI) return INT36_HI;
        if (v < INT36_LO) return INT36_LO;
        return v;
    endfunction

    // Runs the sixteen interpolated sub-steps for one sample and updates
    // that channel's state; a bad channel touches nothing.
    function automatic t_dsd_word modulate_sample(input logic [CHAN_W-1:0] ch,
                                                  input logic signed [PCM_W-1:0] pcm);
        t_dsd_word     res;
        logic [CH_W-1:0] idx;
        longint        smp, prv, dlt, x, acc1, acc2, fbk;
        res = '0;
        if (ch >= CHANNELS) begin
            res.bits = BAD_CHAN_WORD;
            res.bad  = 1'b1;
            return res;
        end
        idx = ch[CH_W-1:0];
        // Q8.23 read as Q.24 is already halved; clamp to +/-0.5
        smp = longint'(pcm);
        if (smp > HALF_Q24)  smp = HALF_Q24;
        if (smp < -HALF_Q24) smp = -HALF_Q24;
        prv  = longint'(chan_last[idx]);
        dlt  = smp - prv;
        acc1 = longint'(chan_int1[idx]);
        acc2 = longint'(chan_int2[idx]);
        fbk  = chan_dec[idx] ? ONE_Q28 : -ONE_Q28;
        for (int k = 1; k <= SUB_STEPS; k++) begin
            x    = prv * 16 + dlt * k;
            acc1 = clip36(acc1 + x - fbk);
            acc2 = clip36(acc2 + acc1 - fbk);
            fbk  = (acc2 >= 0) ? ONE_Q28 : -ONE_Q28;
            res.bits = {res.bits[DSD_W-2:0], acc2 >= 0};
        end
        chan_last[idx] = smp[24:0];
        chan_int1[idx] = acc1[35:0];
        chan_int2[idx] = acc2[35:0];
        chan_dec[idx]  = (fbk > 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // --------------------------------------------------------------------
    // Sender: offers one item, holds it until accepted, then records the
    // expected result. Valid only drops when a gap is actually inserted,
    // so back-to-back items keep it high with a single update per edge.
    // --------------------------------------------------------------------
    task automatic send_item(input logic [CHAN_W-1:0] ch, input logic signed [PCM_W-1:0] pcm,
                             input bit typed, input t_dsd_word typed_word);
        t_dsd_word predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_chan       <= ch;
        i_pcm_sample <= pcm;
        do @(posedge i_clk); while (o_stall);
        // accepted at this edge; the predictor state advances for every good channel, typed rows included
        predicted = modulate_sample(ch, pcm);
        pending_dsd.push_back(typed ? typed_word : predicted);
        items_sent++;
        if (ch >= CHANNELS) bad_items++;
    endtask

    // Random items: mostly in-range samples on good channels, with runs on
    // one channel to exercise the same-channel hold, plus full-scale noise,
    // rail values and the odd bad channel.
    task automatic run_random_phase(input int count);
        logic [CHAN_W-1:0]       ch;
        logic signed [PCM_W-1:0] pcm;
        int                      pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 12)      ch = CHAN_W'($urandom_range(CHANNELS, 63));
            else if (pick < 34) ch = prev_chan;
            else                ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
            prev_chan = ch;

            pick = $urandom_range(99);
            if (pick < 55) begin
                pcm = PCM_W'(int'($urandom_range(0, 16777216)) - 8388608);
            end else if (pick < 70) begin
                pcm = PCM_W'(int'($urandom_range(0, 4000)) - 2000);
            end else if (pick < 90) begin
                pcm = PCM_W'($urandom);
            end else begin
                case ($urandom_range(3))
                    0:       pcm = 32'sh7FFF_FFFF;
                    1:       pcm = 32'sh8000_0000;
                    2:       pcm = 32'sh0080_0000;
                    default: pcm = 32'shFF80_0000;
                endcase
            end
            send_item(ch, pcm, 1'b0, '0);
        end
    endtask

    // --------------------------------------------------------------------
    // Receiver: checks each accepted result against the oldest expectation
    // and draws the next stall. Both read pre-edge values only.
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dsd_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dsd.size() == 0) begin
                report_mismatch("result with nothing pending",
                                32'({o_bad_channel, o_dsd_bits}), '0);
            end else begin
                want = pending_dsd.pop_front();
                results_checked++;
                if (o_dsd_bits !== want.bits)
                    report_mismatch("dsd_bits", 32'(o_dsd_bits), 32'(want.bits));
                if (o_bad_channel !== want.bad)
                    report_mismatch("bad_channel", 32'(o_bad_channel), 32'(want.bad));
            end
        end
        if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("timeout with %0d results pending", pending_dsd.size());
        $display("FAILED: results differ");
        $finish;
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            chan_last[c] = '0;
            chan_int1[c] = '0;
            chan_int2[c] = '0;
            chan_dec[c]  = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: sender mostly busy, receiver mostly stalled
        for (int r = 0; r < N_ROWS; r++)
            send_item(directed_rows[r].chan, directed_rows[r].pcm,
                      directed_rows[r].typed, directed_rows[r].word);
        run_random_phase(PHASE_ITEMS);

        // phase 2: roles swapped
        send_idle_pct  = 71;
        recv_idle_pct <= 19;
        run_random_phase(PHASE_ITEMS);

        // phase 3: no idling, but the receiver blocks for a long stretch at
        // the start so the pipeline and queue fill and back up the input
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random_phase(PHASE_ITEMS);
        i_valid <= 1'b0;

        while (pending_dsd.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d on bad channels), %0d results compared.",
                 items_sent, bad_items, results_checked);
        $display("Clamping, rail swings, same-channel runs and a %0d-cycle hold-off exercised.",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### pcm_to_dsd_sigma_delta.f
design/pds_pkg.sv
design/pds_front.sv
design/pds_fifo.sv
design/pds_back.sv
design/pcm_to_dsd_sigma_delta.sv
verif/tb_pcm_to_dsd_sigma_delta.sv
